@@ src/hashed_value_noise_fbm_top_defines.svh @@
// Assertion macros used by the noise block top level.
`ifndef HASHED_VALUE_NOISE_FBM_TOP_DEFINES_SVH
`define HASHED_VALUE_NOISE_FBM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define HVN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HVN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HVN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define HVN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/hvn_pkg.sv @@
// Types, constants and helpers of the hashed value noise block.
package hvn_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int FRAC_BITS   = 16;
    localparam int OCT_W       = $clog2(MAX_OCTAVES);
    localparam int OCTS_W      = 4;
    localparam int COORD_W     = 32;
    localparam int SH_W        = COORD_W + FRAC_BITS;
    localparam int AMP_W       = 17;
    localparam int AMP_FRAC    = 16;
    localparam int SMOOTH_W    = FRAC_BITS + 1;
    localparam int DIFF_W      = 33;
    localparam int BLEND_W     = DIFF_W + SMOOTH_W + 1;
    localparam int PROD_W      = COORD_W + AMP_W + 1;
    localparam int TOT_W       = PROD_W + OCT_W;
    localparam int WGT_W       = AMP_W + OCT_W;
    localparam int DIVD_W      = TOT_W - AMP_FRAC;
    localparam int Q_W         = 16;
    localparam int OUT_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 32;

    localparam logic [31:0] HASH_MUL_A    = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL_B    = 32'h846ca68b;
    localparam logic [31:0] LATTICE_MUL_X = 32'h9e3779b1;
    localparam logic [31:0] LATTICE_MUL_Y = 32'h85ebca6b;

    localparam logic [AMP_W-1:0]  UNIT_AMP = 17'h10000;
    localparam logic [OUT_W-1:0]  OUT_MAX  = 16'h7fff;

    localparam logic [CFG_IDX_W-1:0] REG_SEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OCTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_D = 2'd3;

    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic                 two_d;
        logic [AMP_W-1:0]     amp;
        logic [31:0]          sd;
        logic [31:0]          ix;
        logic [31:0]          iy;
        logic [FRAC_BITS-1:0] tx;
        logic [FRAC_BITS-1:0] ty;
    } oct_in_t;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic [AMP_W-1:0]         amp;
        logic signed [PROD_W-1:0] contrib;
    } oct_out_t;

    function automatic logic signed [31:0] corner_value(input logic [31:0] h);
        return {~h[31], h[30:0]};
    endfunction

endpackage

@@ src/hashed_value_noise_fbm_top.sv @@
// Seeded fractal value noise: input queue, octave sequencer and pipeline, divider.
//
// Input stream s_axis carries one coordinate pair per transaction; m_axis returns
// one signed Q1.15 noise sample per input, in order. Configuration registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only while
// no transaction is in flight, as the block does not enforce it. The single shared
// octave pipeline evaluates the octaves of each input, N = effective octave count
// (1..8), at one octave per cycle while input is queued and output slots are free;
// results pass the octave stages, accumulator, 18 divider stages and output queue.
// Up to OUT_DEPTH samples may be in flight; a new item starts only when a slot in
// the output queue is reserved for it, so a stalled receiver fills the output
// queue, then the pipeline drains into it and s_axis_tready drops once the input
// queue is full. No result is lost or repeated under any stall pattern.
// Reset clears all queues and in-flight work and loads seed 0, one octave,
// persistence 0.5 and two-dimensional mode.
module hashed_value_noise_fbm_top #(
    parameter int IN_DEPTH  = 2,
    parameter int OUT_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,  // coord_x[31:0], coord_y[63:32]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [hvn_pkg::OUT_W-1:0]         m_axis_tdata,  // noise_value[15:0]
    input  logic                              cfg_we,
    input  logic [hvn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hvn_pkg::CFG_W-1:0]         cfg_data
);
    import hvn_pkg::*;
`include "hashed_value_noise_fbm_top_defines.svh"

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic [31:0]       seed_reg;
    logic [OCTS_W-1:0] octs_reg;
    logic [AMP_W-1:0]  pers_reg;
    logic              two_d_reg;

    logic              q_valid, q_ready;
    logic [63:0]       q_data;
    logic [31:0]       xs, ys;
    logic [SH_W-1:0]   xs_sh, ys_sh;
    logic [OCTS_W-1:0] octs_eff;
    logic [AMP_W-1:0]  pers_eff, amp_cur;
    logic [2*AMP_W-1:0] amp_prod;
    logic [OCT_W-1:0]  k_reg, k_next;
    logic [AMP_W-1:0]  amp_reg, amp_next;
    logic              first, last_oct, issue;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    oct_in_t           iss_reg, iss_next;
    oct_out_t          oct_out;

    logic signed [TOT_W-1:0] total_reg, total_next, sum_t, div_total_reg;
    logic [WGT_W-1:0]        weight_reg, weight_next, sum_w, div_weight_reg;
    logic                    div_vld_reg;
    logic                    div_out_valid;
    logic [OUT_W-1:0]        div_out_value;
    logic                    outq_in_ready;
    logic                    out_xfer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            octs_reg  <= OCTS_W'(1);
            pers_reg  <= AMP_W'(32768);
            two_d_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEED:  seed_reg  <= cfg_data;
                REG_OCTS:  octs_reg  <= cfg_data[OCTS_W-1:0];
                REG_PERS:  pers_reg  <= cfg_data[AMP_W-1:0];
                REG_TWO_D: two_d_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    hvn_queue #(
        .WIDTH(64),
        .DEPTH(IN_DEPTH)
    ) u_in_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_data)
    );

    always_comb
    begin
        xs = q_data[31:0];
        ys = q_data[63:32];
        if (octs_reg == '0)
        begin
            octs_eff = OCTS_W'(1);
        end
        else if (octs_reg > OCTS_W'(MAX_OCTAVES))
        begin
            octs_eff = OCTS_W'(MAX_OCTAVES);
        end
        else
        begin
            octs_eff = octs_reg;
        end
        pers_eff = (pers_reg > UNIT_AMP) ? UNIT_AMP : pers_reg;

        first    = (k_reg == '0);
        last_oct = (OCTS_W'(k_reg) == octs_eff - 1'b1);
        issue    = q_valid && (!first || (cnt_reg < CNT_W'(OUT_DEPTH)));
        q_ready  = issue && last_oct;

        amp_cur  = first ? UNIT_AMP : amp_reg;
        amp_prod = amp_cur * pers_eff;
        amp_next = issue ? amp_prod[AMP_FRAC+AMP_W-1:AMP_FRAC] : amp_reg;
        k_next   = k_reg;
        if (issue)
        begin
            k_next = last_oct ? '0 : k_reg + 1'b1;
        end

        xs_sh = {{FRAC_BITS{xs[31]}}, xs} << k_reg;
        ys_sh = {{FRAC_BITS{ys[31]}}, ys} << k_reg;
        iss_next.valid = issue;
        iss_next.last  = last_oct;
        iss_next.two_d = two_d_reg;
        iss_next.amp   = amp_cur;
        iss_next.sd    = seed_reg + 32'(k_reg);
        iss_next.ix    = xs_sh[SH_W-1:FRAC_BITS];
        iss_next.iy    = ys_sh[SH_W-1:FRAC_BITS];
        iss_next.tx    = xs_sh[FRAC_BITS-1:0];
        iss_next.ty    = ys_sh[FRAC_BITS-1:0];

        out_xfer = m_axis_tvalid && m_axis_tready;
        cnt_next = cnt_reg;
        if ((issue && first) && !out_xfer)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!(issue && first) && out_xfer)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= '0;
            cnt_reg <= '0;
            iss_reg <= '0;
        end
        else
        begin
            k_reg   <= k_next;
            cnt_reg <= cnt_next;
            iss_reg <= iss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amp_reg <= amp_next;
    end

    hvn_octave u_octave (
        .clk  (clk),
        .rst_n(rst_n),
        .oin  (iss_reg),
        .oout (oct_out)
    );

    always_comb
    begin
        sum_t       = total_reg + TOT_W'(oct_out.contrib);
        sum_w       = weight_reg + WGT_W'(oct_out.amp);
        total_next  = total_reg;
        weight_next = weight_reg;
        if (oct_out.valid)
        begin
            total_next  = oct_out.last ? '0 : sum_t;
            weight_next = oct_out.last ? '0 : sum_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            weight_reg  <= '0;
            div_vld_reg <= 1'b0;
        end
        else
        begin
            total_reg   <= total_next;
            weight_reg  <= weight_next;
            div_vld_reg <= oct_out.valid && oct_out.last;
        end
    end

    always_ff @(posedge clk)
    begin
        div_total_reg  <= sum_t;
        div_weight_reg <= sum_w;
    end

    hvn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_vld_reg),
        .in_total (div_total_reg),
        .in_weight(div_weight_reg),
        .out_valid(div_out_valid),
        .out_value(div_out_value)
    );

    hvn_queue #(
        .WIDTH(OUT_W),
        .DEPTH(OUT_DEPTH)
    ) u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_out_valid),
        .in_ready (outq_in_ready),
        .in_data  (div_out_value),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (m_axis_tdata)
    );

    `HVN_ASSERT_IMP(a_credit_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(OUT_DEPTH), "credit count above output queue depth")
    `HVN_ASSERT_IMP(a_outq_no_overflow, clk, rst_n, div_out_valid, outq_in_ready, "result pushed into full output queue")
    `HVN_ASSERT_NXT(a_last_octave_closes, clk, rst_n, oct_out.valid && oct_out.last, div_vld_reg, "final octave did not reach divider")

endmodule

@@ src/hvn_mix.sv @@
// Two-stage xorshift-multiply hash mixer.
module hvn_mix (
    input  logic        clk,
    input  logic [31:0] din,
    output logic [31:0] dout
);
    import hvn_pkg::*;

    logic [31:0] s1_reg, s1_next;
    logic [31:0] s2_reg, s2_next;
    logic [31:0] v0, v1;

    always_comb
    begin
        v0      = din ^ (din >> 16);
        s1_next = 32'(v0 * HASH_MUL_A);
        v1      = s1_reg ^ (s1_reg >> 15);
        s2_next = 32'(v1 * HASH_MUL_B);
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign dout = s2_reg ^ (s2_reg >> 16);

endmodule

@@ src/hvn_queue.sv @@
// Small register FIFO with valid/ready on both sides.
module hvn_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ src/hvn_octave.sv @@
// Pipelined single-octave evaluator: lattice hashes, smoothstep, blend, weight.
module hvn_octave (
    input  logic             clk,
    input  logic             rst_n,
    input  hvn_pkg::oct_in_t oin,
    output hvn_pkg::oct_out_t oout
);
    import hvn_pkg::*;

    typedef struct packed {
        logic                valid;
        logic                last;
        logic                two_d;
        logic [AMP_W-1:0]    amp;
        logic [SMOOTH_W-1:0] sx;
        logic [SMOOTH_W-1:0] sy;
    } side_t;

    localparam int LAST_ST = 8;

    side_t side_reg [1:LAST_ST];
    side_t side_next [1:LAST_ST];

    // stage 1
    logic [31:0] mx0_1_reg, mx1_1_reg, my0_1_reg, my1_1_reg;
    logic [2*FRAC_BITS-1:0] ttx_1_reg, tty_1_reg;
    logic [FRAC_BITS-1:0] tx_1_reg, ty_1_reg;
    logic [31:0] ix1, iy1;
    // stage 2
    logic [31:0] mx0_2_reg, mx1_2_reg;
    logic [FRAC_BITS+1:0] k3x, k3y;
    logic [2*FRAC_BITS+1:0] spx, spy;
    logic [31:0] msd, hx0, hx1;
    // stage 3..6
    logic [31:0] mym0, mym1, mym0_4_reg, mym1_4_reg;
    logic [31:0] h10, h11, h10_5_reg, h11_5_reg, h10_6_reg, h11_6_reg;
    logic [31:0] g00, g10, g01, g11;
    logic [31:0] h200, h210, h201, h211;
    logic signed [31:0] v00, v10, v01, v11;
    logic signed [DIFF_W-1:0] d0, d1, dy;
    logic signed [BLEND_W-1:0] p0_next, p1_next, p0_7_reg, p1_7_reg;
    logic signed [31:0] v00_7_reg, v01_7_reg;
    // stage 7..8
    logic [DIFF_W-1:0] r0x, r1x, nx;
    logic signed [31:0] r0, r1, n;
    logic signed [BLEND_W-1:0] py_next, py_8_reg;
    logic signed [31:0] r0_8_reg;
    oct_out_t oout_reg, oout_next;

    assign ix1 = oin.ix + 32'd1;
    assign iy1 = oin.iy + 32'd1;

    hvn_mix u_mix_sd  (.clk(clk), .din(oin.sd),    .dout(msd));
    hvn_mix u_mix_my0 (.clk(clk), .din(my0_1_reg), .dout(mym0));
    hvn_mix u_mix_my1 (.clk(clk), .din(my1_1_reg), .dout(mym1));
    hvn_mix u_mix_hx0 (.clk(clk), .din(hx0),       .dout(h10));
    hvn_mix u_mix_hx1 (.clk(clk), .din(hx1),       .dout(h11));
    hvn_mix u_mix_g00 (.clk(clk), .din(g00),       .dout(h200));
    hvn_mix u_mix_g10 (.clk(clk), .din(g10),       .dout(h210));
    hvn_mix u_mix_g01 (.clk(clk), .din(g01),       .dout(h201));
    hvn_mix u_mix_g11 (.clk(clk), .din(g11),       .dout(h211));

    always_comb
    begin
        side_next[1]       = '0;
        side_next[1].valid = oin.valid;
        side_next[1].last  = oin.last;
        side_next[1].two_d = oin.two_d;
        side_next[1].amp   = oin.amp;

        k3x = (FRAC_BITS + 2)'(3 << FRAC_BITS) - {1'b0, tx_1_reg, 1'b0};
        k3y = (FRAC_BITS + 2)'(3 << FRAC_BITS) - {1'b0, ty_1_reg, 1'b0};
        spx = ttx_1_reg[2*FRAC_BITS-1:FRAC_BITS] * k3x;
        spy = tty_1_reg[2*FRAC_BITS-1:FRAC_BITS] * k3y;
        side_next[2]    = side_reg[1];
        side_next[2].sx = spx[2*FRAC_BITS:FRAC_BITS];
        side_next[2].sy = spy[2*FRAC_BITS:FRAC_BITS];
        for (int i = 3; i <= LAST_ST; i++)
        begin
            side_next[i] = side_reg[i-1];
        end

        hx0 = mx0_2_reg ^ msd;
        hx1 = mx1_2_reg ^ msd;

        g00 = h10 ^ mym0_4_reg;
        g10 = h11 ^ mym0_4_reg;
        g01 = h10 ^ mym1_4_reg;
        g11 = h11 ^ mym1_4_reg;

        v00 = corner_value(side_reg[6].two_d ? h200 : h10_6_reg);
        v10 = corner_value(side_reg[6].two_d ? h210 : h11_6_reg);
        v01 = corner_value(h201);
        v11 = corner_value(h211);
        d0  = {v10[31], v10} - {v00[31], v00};
        d1  = {v11[31], v11} - {v01[31], v01};
        p0_next = d0 * $signed({1'b0, side_reg[6].sx});
        p1_next = d1 * $signed({1'b0, side_reg[6].sx});

        r0x = {v00_7_reg[31], v00_7_reg} + p0_7_reg[FRAC_BITS+DIFF_W-1:FRAC_BITS];
        r1x = {v01_7_reg[31], v01_7_reg} + p1_7_reg[FRAC_BITS+DIFF_W-1:FRAC_BITS];
        r0  = $signed(r0x[31:0]);
        r1  = $signed(r1x[31:0]);
        dy  = {r1[31], r1} - {r0[31], r0};
        py_next = dy * $signed({1'b0, side_reg[7].sy});

        nx = {r0_8_reg[31], r0_8_reg} + py_8_reg[FRAC_BITS+DIFF_W-1:FRAC_BITS];
        n  = side_reg[8].two_d ? $signed(nx[31:0]) : r0_8_reg;
        oout_next.valid   = side_reg[8].valid;
        oout_next.last    = side_reg[8].last;
        oout_next.amp     = side_reg[8].amp;
        oout_next.contrib = n * $signed({1'b0, side_reg[8].amp});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= LAST_ST; i++)
            begin
                side_reg[i] <= '0;
            end
            oout_reg <= '0;
        end
        else
        begin
            for (int i = 1; i <= LAST_ST; i++)
            begin
                side_reg[i] <= side_next[i];
            end
            oout_reg <= oout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx0_1_reg  <= 32'(oin.ix * LATTICE_MUL_X);
        mx1_1_reg  <= 32'(ix1 * LATTICE_MUL_X);
        my0_1_reg  <= 32'(oin.iy * LATTICE_MUL_Y);
        my1_1_reg  <= 32'(iy1 * LATTICE_MUL_Y);
        ttx_1_reg  <= oin.tx * oin.tx;
        tty_1_reg  <= oin.ty * oin.ty;
        tx_1_reg   <= oin.tx;
        ty_1_reg   <= oin.ty;
        mx0_2_reg  <= mx0_1_reg;
        mx1_2_reg  <= mx1_1_reg;
        mym0_4_reg <= mym0;
        mym1_4_reg <= mym1;
        h10_5_reg  <= h10;
        h11_5_reg  <= h11;
        h10_6_reg  <= h10_5_reg;
        h11_6_reg  <= h11_5_reg;
        p0_7_reg   <= p0_next;
        p1_7_reg   <= p1_next;
        v00_7_reg  <= v00;
        v01_7_reg  <= v01;
        py_8_reg   <= py_next;
        r0_8_reg   <= r0;
    end

    assign oout = oout_reg;

endmodule

@@ src/hvn_div.sv @@
// Pipelined restoring divider: weighted sum over total weight, saturated to Q1.15.
module hvn_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [hvn_pkg::TOT_W-1:0]  in_total,
    input  logic [hvn_pkg::WGT_W-1:0]         in_weight,
    output logic                              out_valid,
    output logic [hvn_pkg::OUT_W-1:0]         out_value
);
    import hvn_pkg::*;

    logic [DIVD_W-1:0] rem_reg [0:Q_W];
    logic [DIVD_W-1:0] rem_next [0:Q_W];
    logic [Q_W-1:0]    quo_reg [0:Q_W];
    logic [Q_W-1:0]    quo_next [0:Q_W];
    logic [WGT_W-1:0]  den_reg [0:Q_W];
    logic              neg_reg [0:Q_W];
    logic              vld_reg [0:Q_W];
    logic [TOT_W-1:0]  mag;
    logic [DIVD_W-1:0] den_sh;
    logic [Q_W-1:0]    q;
    logic [OUT_W-1:0]  res_reg, res_next;
    logic              out_vld_reg;

    always_comb
    begin
        mag = in_total[TOT_W-1] ? (~in_total + 1'b1) : in_total;
        rem_next[0] = mag[TOT_W-1:AMP_FRAC];
        quo_next[0] = '0;
        den_sh = '0;
        for (int s = 0; s < Q_W; s++)
        begin
            den_sh = DIVD_W'(den_reg[s]) << (Q_W - 1 - s);
            rem_next[s+1] = rem_reg[s];
            quo_next[s+1] = quo_reg[s];
            if (rem_reg[s] >= den_sh)
            begin
                rem_next[s+1] = rem_reg[s] - den_sh;
                quo_next[s+1] = quo_reg[s] | (Q_W'(1) << (Q_W - 1 - s));
            end
        end
        q = quo_reg[Q_W];
        if (neg_reg[Q_W])
        begin
            res_next = OUT_W'(~q + 1'b1);
        end
        else if (q > OUT_W'(OUT_MAX))
        begin
            res_next = OUT_MAX;
        end
        else
        begin
            res_next = OUT_W'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= Q_W; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= Q_W; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            out_vld_reg <= vld_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_next[0];
        quo_reg[0] <= quo_next[0];
        den_reg[0] <= in_weight;
        neg_reg[0] <= in_total[TOT_W-1];
        for (int s = 1; s <= Q_W; s++)
        begin
            rem_reg[s] <= rem_next[s];
            quo_reg[s] <= quo_next[s];
            den_reg[s] <= den_reg[s-1];
            neg_reg[s] <= neg_reg[s-1];
        end
        res_reg <= res_next;
    end

    assign out_valid = out_vld_reg;
    assign out_value = res_reg;

endmodule

@@ dv/tb_hashed_value_noise_fbm_top.sv @@
// Self-checking testbench for the seeded fractal value noise block.
module tb_hashed_value_noise_fbm_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hvn_pkg::*;

    class noise_scoreboard;
        logic [31:0]      seed;
        logic [OCTS_W-1:0] octs;
        logic [AMP_W-1:0] pers;
        logic             two_d;
        logic [OUT_W-1:0] pending[$];
        int               errors;
        int               checked;

        function new();
            seed = '0;
            octs = 1;
            pers = 17'd32768;
            two_d = 1'b1;
            errors = 0;
            checked = 0;
        endfunction

        function logic [31:0] mix(logic [31:0] v);
            v = v ^ (v >> 16);
            v = v * HASH_MUL_A;
            v = v ^ (v >> 15);
            v = v * HASH_MUL_B;
            v = v ^ (v >> 16);
            return v;
        endfunction

        function logic [31:0] hash_x(logic [31:0] cx, logic [31:0] sd);
            logic [31:0] m;
            m = cx * LATTICE_MUL_X;
            return mix(m ^ mix(sd));
        endfunction

        function logic [31:0] hash_xy(logic [31:0] cx, logic [31:0] cy, logic [31:0] sd);
            logic [31:0] m;
            m = cy * LATTICE_MUL_Y;
            return mix(hash_x(cx, sd) ^ mix(m));
        endfunction

        function longint corner(logic [31:0] h);
            return longint'({32'b0, h}) - 64'sh80000000;
        endfunction

        function longint smooth(longint unsigned t);
            longint unsigned t2;
            longint unsigned k;
            t2 = (t * t) >> FRAC_BITS;
            k = (64'd3 << FRAC_BITS) - 2 * t;
            return longint'((t2 * k) >> FRAC_BITS);
        endfunction

        function longint mixval(longint a, longint b, longint s);
            longint p;
            p = (b - a) * s;
            return a + (p >>> FRAC_BITS);
        endfunction

        function logic [OUT_W-1:0] predict(logic signed [31:0] x, logic signed [31:0] y);
            longint unsigned xs, ys, px, py, amp, pf;
            longint          total, weight, n, sx, sy, r0, r1, q;
            logic [31:0]     ix, ix1, iy, iy1, sd;
            int              no;
            xs = longint'(x);
            ys = longint'(y);
            no = (octs < 1) ? 1 : (octs > MAX_OCTAVES) ? MAX_OCTAVES : octs;
            pf = (pers > 17'h10000) ? 64'd65536 : 64'(pers);
            amp = 65536;
            total = 0;
            weight = 0;
            for (int k = 0; k < no; k++)
            begin
                sd = seed + k;
                px = xs << k;
                ix = px[47:16];
                ix1 = ix + 1;
                sx = smooth(px[15:0]);
                if (two_d)
                begin
                    py = ys << k;
                    iy = py[47:16];
                    iy1 = iy + 1;
                    sy = smooth(py[15:0]);
                    r0 = mixval(corner(hash_xy(ix, iy, sd)), corner(hash_xy(ix1, iy, sd)), sx);
                    r1 = mixval(corner(hash_xy(ix, iy1, sd)), corner(hash_xy(ix1, iy1, sd)), sx);
                    n = mixval(r0, r1, sy);
                end
                else
                begin
                    n = mixval(corner(hash_x(ix, sd)), corner(hash_x(ix1, sd)), sx);
                end
                total += n * longint'(amp);
                weight += longint'(amp);
                amp = (amp * pf) >> 16;
            end
            q = total / (weight * 65536);
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            return q[15:0];
        endfunction

        function void note_input(logic [31:0] x, logic [31:0] y);
            pending = {pending, predict(x, y)};
        endfunction

        function void check_result(logic [OUT_W-1:0] act);
            logic [OUT_W-1:0] exp_v;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected noise_value %h", $time, act);
                return;
            end
            exp_v = pending.pop_front();
            if (exp_v !== act)
            begin
                errors++;
                $display("%0t: noise_value expected %h actual %h", $time, exp_v, act);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    noise_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int sent = 0;

    hashed_value_noise_fbm_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tdata[31:0], s_axis_tdata[63:32]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SEED:  sb.seed = val;
            REG_OCTS:  sb.octs = val[OCTS_W-1:0];
            REG_PERS:  sb.pers = val[AMP_W-1:0];
            REG_TWO_D: sb.two_d = val[0];
            default: ;
        endcase
    endtask

    task automatic send_item(logic [31:0] x, logic [31:0] y);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y, x};
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000))) - 32'sd1000 << 12;
            2: return {$urandom_range(1) ? 16'h7fff : 16'h8000, 16'($urandom())};
            default: return {16'($urandom_range(8)), 16'($urandom())};
        endcase
    endfunction

    task automatic run_phase(logic [31:0] seed, logic [3:0] octs, logic [16:0] pers,
                             logic two_d, int mode, int n, bit pressure);
        write_reg(REG_SEED, seed);
        write_reg(REG_OCTS, octs);
        write_reg(REG_PERS, pers);
        write_reg(REG_TWO_D, two_d);
        send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 46 : 14) : 0;
        recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 46 : 14) : 0;
        if (pressure)
            hold_req = 500;
        for (int i = 0; i < n; i++)
            send_item(rand_coord(), rand_coord());
        drain();
    endtask

    initial
    begin
        logic [31:0] corners[6];
        corners = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0000ffff,
                    32'h00010000};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset configuration, field extremes
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 3; j++)
                send_item(corners[i], corners[(i + j * 2) % 6]);
        drain();
        // 1D mode, octave count zero, persistence saturation and lattice wrap
        write_reg(REG_TWO_D, 0);
        write_reg(REG_OCTS, 0);
        send_item(32'h7fffffff, 32'h12345678);
        send_item(32'hffff8000, 32'h0);
        drain();
        write_reg(REG_OCTS, 4'hf);
        write_reg(REG_PERS, 17'h1ffff);
        send_item(32'h7fffffff, 32'h0);
        send_item(32'h80000000, 32'hffffffff);
        drain();

        run_phase(32'hffffffff, 4'd8, 17'h10000, 1'b1, 0, 150, 1'b0);
        run_phase($urandom(), 4'd0, 17'h0, 1'b0, 1, 150, 1'b0);
        run_phase($urandom(), 4'hf, 17'h1ffff, 1'b1, 2, 150, 1'b1);
        run_phase($urandom(), 4'($urandom_range(8, 1)), 17'($urandom()), 1'b0, 3, 150, 1'b0);
        run_phase($urandom(), 4'($urandom_range(8, 1)), 17'($urandom_range(65536)), 1'b1,
                  3, 150, 1'b0);
        run_phase(32'h0, 4'd1, 17'($urandom()), 1'b1, 1, 150, 1'b0);

        $display("Sent %0d coordinate pairs across 1D/2D modes, 0..15 octaves and", sent);
        $display("persistence 0..max, with idle, stall and backpressure; %0d samples checked",
                 sb.checked);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
